/* sv/vtdi_pkg.sv */
`timescale 1ns / 1ps
package vtdi_pkg;

   localparam int TABLE_DEPTH    = 1024;
   localparam int MAX_COMPONENTS = 4;
   localparam int INDEX_BITS     = 16;

   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int KEY_BITS    = MAX_COMPONENTS * INDEX_BITS;
   localparam int CCOUNT_BITS = 3;

   localparam logic [CCOUNT_BITS-1:0] CCOUNT_RESET = CCOUNT_BITS'(3);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // capture key, clear table on start of mesh
      logic rd_en;        // read the next slot
      logic finish_hit;   // report the matching slot
      logic finish_miss;  // append the key or report a full table
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;  // slots left to read
      logic pend;  // a read result is waiting for compare
      logic hit;   // the read result matches the key
   } status_type;

endpackage

/* sv/vtdi_ctrl.sv */
`timescale 1ns / 1ps
module vtdi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  vtdi_pkg::status_type status,
   output vtdi_pkg::cmd_type    cmd
);
   import vtdi_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit || (!status.more && !status.pend)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_SCAN: begin
            busy             = 1'b1;
            cmd.rd_en        = status.more && !status.hit;
            cmd.finish_hit   = status.hit;
            cmd.finish_miss  = !status.hit && !status.more && !status.pend;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

/* sv/vtdi_datapath.sv */
`timescale 1ns / 1ps
module vtdi_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  vtdi_pkg::cmd_type                  cmd,
   output vtdi_pkg::status_type               status,
   input  logic                               start_of_mesh,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    component_0,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    component_1,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    component_2,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    component_3,
   input  logic                               ccount_wr_en,
   input  logic [vtdi_pkg::CCOUNT_BITS-1:0]   ccount_wr_data,
   output logic                               rsp_valid,
   output logic [vtdi_pkg::ADDR_BITS-1:0]     vertex_index,
   output logic                               is_new,
   output logic                               table_full
);
   import vtdi_pkg::*;

   logic [KEY_BITS-1:0] tuple_store_mem [TABLE_DEPTH];

   logic [CCOUNT_BITS-1:0] ccount_ff, ccount_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  scan_ff, scan_in;
   logic [ADDR_BITS-1:0]   rd_addr_ff;
   logic                   rd_valid_ff;
   logic [KEY_BITS-1:0]    rd_data_ff;
   logic                   rsp_valid_ff;
   logic [ADDR_BITS-1:0]   vidx_ff, vidx_in;
   logic                   is_new_ff, is_new_in;
   logic                   full_ff, full_in;

   logic [CCOUNT_BITS-1:0] used_count;
   logic [INDEX_BITS-1:0]  comp [MAX_COMPONENTS];
   logic                   wr_en;
   logic                   table_is_full;

   assign comp[0] = component_0;
   assign comp[1] = component_1;
   assign comp[2] = component_2;
   assign comp[3] = component_3;

   // saturate the key length to 1..MAX_COMPONENTS
   always_comb begin
      priority if (ccount_ff == '0) begin
         used_count = CCOUNT_BITS'(1);
      end else if (ccount_ff > CCOUNT_BITS'(MAX_COMPONENTS)) begin
         used_count = CCOUNT_BITS'(MAX_COMPONENTS);
      end else begin
         used_count = ccount_ff;
      end
   end

   // unused components are zero in both stored and compared keys
   always_comb begin
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
         key_in[c*INDEX_BITS +: INDEX_BITS] =
            (CCOUNT_BITS'(c) < used_count) ? comp[c] : '0;
      end
   end

   assign table_is_full = count_ff[ADDR_BITS];
   assign wr_en         = cmd.finish_miss && !table_is_full;

   assign status.more = scan_ff < count_ff;
   assign status.pend = rd_valid_ff;
   assign status.hit  = rd_valid_ff && (rd_data_ff == key_ff);

   assign ccount_in = ccount_wr_en ? ccount_wr_data : ccount_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.load && start_of_mesh) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.load) begin
         scan_in = '0;
      end else if (cmd.rd_en) begin
         scan_in = scan_ff + COUNT_BITS'(1);
      end
   end

   always_comb begin
      vidx_in   = vidx_ff;
      is_new_in = is_new_ff;
      full_in   = full_ff;
      if (cmd.finish_hit) begin
         vidx_in   = rd_addr_ff;
         is_new_in = 1'b0;
         full_in   = 1'b0;
      end else if (cmd.finish_miss) begin
         vidx_in   = table_is_full ? '0 : count_ff[ADDR_BITS-1:0];
         is_new_in = !table_is_full;
         full_in   = table_is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ccount_ff    <= CCOUNT_RESET;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ccount_ff    <= ccount_in;
         count_ff     <= count_in;
         rd_valid_ff  <= cmd.rd_en;
         rsp_valid_ff <= cmd.finish_hit || cmd.finish_miss;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      rd_addr_ff <= scan_ff[ADDR_BITS-1:0];
      vidx_ff    <= vidx_in;
      is_new_ff  <= is_new_in;
      full_ff    <= full_in;
      if (cmd.load) begin
         key_ff <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tuple_store_mem[count_ff[ADDR_BITS-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= tuple_store_mem[scan_ff[ADDR_BITS-1:0]];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign vertex_index = vidx_ff;
   assign is_new       = is_new_ff;
   assign table_full   = full_ff;

endmodule

/* sv/vertex_tuple_dedup_indexer.sv */
`timescale 1ns / 1ps
// Vertex tuple de-duplicating indexer.
// Input: one triangle corner per transaction, accepted on a rising edge with
// start high and busy low. The first csr component_count components form the
// key (0 acts as 1, above 4 acts as 4); req_start_of_mesh empties the table.
// Output: exactly one result per corner, shown for one cycle with rsp_valid
// high; the receiver must take it then, it cannot stall the block.
// Lookup scans the stored tuples in order through the single read port of the
// tuple memory, one slot per cycle, with a compare on the registered read data.
// The scan stops at the first matching slot, or, for a new tuple, once every
// stored slot has been read and compared; an empty table needs no read. busy
// falls in the cycle rsp_valid is high, so the next corner can be accepted
// then; one corner at a time is in flight.
// A new tuple is written to slot n and gets vertex number n; on a full table
// it is flagged table_full and not stored.
// csr_wr_en writes component_count at once; write it only while idle.
// Reset empties the table and sets component_count to 3; no clearing pass.
module vertex_tuple_dedup_indexer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_start_of_mesh,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_0,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_1,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_2,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_3,
   output logic                               rsp_valid,
   output logic [vtdi_pkg::ADDR_BITS-1:0]     rsp_vertex_index,
   output logic                               rsp_is_new,
   output logic                               rsp_table_full,
   input  logic                               csr_wr_en,
   input  logic [vtdi_pkg::CCOUNT_BITS-1:0]   csr_wr_data
);
   import vtdi_pkg::*;

   cmd_type    cmd;
   status_type status;

   vtdi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   vtdi_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .start_of_mesh  (req_start_of_mesh),
      .component_0    (req_component_0),
      .component_1    (req_component_1),
      .component_2    (req_component_2),
      .component_3    (req_component_3),
      .ccount_wr_en   (csr_wr_en),
      .ccount_wr_data (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .vertex_index   (rsp_vertex_index),
      .is_new         (rsp_is_new),
      .table_full     (rsp_table_full)
   );

endmodule

/* tb/sv/vtdi_index_checker.sv */
`timescale 1ns / 1ps
module vtdi_index_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_start_of_mesh,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_0,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_1,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_2,
   input  logic [vtdi_pkg::INDEX_BITS-1:0]    req_component_3,
   input  logic                               rsp_valid,
   input  logic [vtdi_pkg::ADDR_BITS-1:0]     rsp_vertex_index,
   input  logic                               rsp_is_new,
   input  logic                               rsp_table_full,
   input  logic                               csr_wr_en,
   input  logic [vtdi_pkg::CCOUNT_BITS-1:0]   csr_wr_data,
   output int                                 mismatch_count,
   output int                                 outstanding,
   output int                                 new_count,
   output int                                 full_count
);
   import vtdi_pkg::*;

   typedef struct packed {
      logic [ADDR_BITS-1:0] vertex_index;
      logic                 is_new;
      logic                 table_full;
   } corner_result_type;

   logic [KEY_BITS-1:0]    known_tuples [TABLE_DEPTH];
   int unsigned            tuple_total;
   logic [CCOUNT_BITS-1:0] key_width_reg;
   corner_result_type      pending_results [$];
   corner_result_type      want;
   int                     errors;
   int                     news;
   int                     fulls;

   initial begin
      errors = 0;
      news = 0;
      fulls = 0;
      tuple_total = 0;
      key_width_reg = CCOUNT_RESET;
   end

   // Look the corner up in the current mesh and append it when new and there is room.
   function automatic corner_result_type index_corner(
      input logic                  som,
      input logic [INDEX_BITS-1:0] c0,
      input logic [INDEX_BITS-1:0] c1,
      input logic [INDEX_BITS-1:0] c2,
      input logic [INDEX_BITS-1:0] c3
   );
      int unsigned         used;
      logic [KEY_BITS-1:0] key;
      corner_result_type   res;
      int                  hit_slot;
      if (key_width_reg == 0)
         used = 1;
      else if (key_width_reg > MAX_COMPONENTS)
         used = MAX_COMPONENTS;
      else
         used = key_width_reg;
      if (som)
         tuple_total = 0;
      // unused components count as zero on store and on compare
      key = '0;
      key[15:0] = c0;
      if (used > 1) key[31:16] = c1;
      if (used > 2) key[47:32] = c2;
      if (used > 3) key[63:48] = c3;
      hit_slot = -1;
      for (int s = 0; s < tuple_total; s++) begin
         if (hit_slot < 0 && known_tuples[s] == key)
            hit_slot = s;
      end
      res = '0;
      if (hit_slot >= 0) begin
         res.vertex_index = ADDR_BITS'(hit_slot);
      end else if (tuple_total < TABLE_DEPTH) begin
         known_tuples[tuple_total] = key;
         res.vertex_index = ADDR_BITS'(tuple_total);
         res.is_new = 1'b1;
         tuple_total++;
      end else begin
         res.table_full = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tuple_total = 0;
         key_width_reg = CCOUNT_RESET;
         pending_results.delete();
      end else begin
         // retire the result first; a new corner may be taken on the same edge
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result with no corner outstanding: index %0d new %0b full %0b",
                      rsp_vertex_index, rsp_is_new, rsp_table_full);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_vertex_index !== want.vertex_index) begin
                  $error("vertex_index: expected %0d, got %0d",
                         want.vertex_index, rsp_vertex_index);
                  errors++;
               end
               if (rsp_is_new !== want.is_new) begin
                  $error("is_new: expected %0b, got %0b", want.is_new, rsp_is_new);
                  errors++;
               end
               if (rsp_table_full !== want.table_full) begin
                  $error("table_full: expected %0b, got %0b",
                         want.table_full, rsp_table_full);
                  errors++;
               end
               if (want.is_new) news++;
               if (want.table_full) fulls++;
            end
         end
         if (csr_wr_en)
            key_width_reg = csr_wr_data;
         if (start && !busy)
            pending_results.push_back(index_corner(req_start_of_mesh, req_component_0,
               req_component_1, req_component_2, req_component_3));
      end
      mismatch_count <= errors;
      outstanding <= pending_results.size();
      new_count <= news;
      full_count <= fulls;
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import vtdi_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_start_of_mesh = 1'b0;
   logic [INDEX_BITS-1:0]  req_component_0 = '0;
   logic [INDEX_BITS-1:0]  req_component_1 = '0;
   logic [INDEX_BITS-1:0]  req_component_2 = '0;
   logic [INDEX_BITS-1:0]  req_component_3 = '0;
   logic                   rsp_valid;
   logic [ADDR_BITS-1:0]   rsp_vertex_index;
   logic                   rsp_is_new;
   logic                   rsp_table_full;
   logic                   csr_wr_en = 1'b0;
   logic [CCOUNT_BITS-1:0] csr_wr_data = '0;

   int mismatch_count;
   int outstanding;
   int new_count;
   int full_count;

   int burst_left = 0;
   int corners_sent = 0;
   int meshes = 0;
   int cfg_writes = 0;

   logic [KEY_BITS-1:0] fill_tuples [TABLE_DEPTH];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vertex_tuple_dedup_indexer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_of_mesh (req_start_of_mesh),
      .req_component_0   (req_component_0),
      .req_component_1   (req_component_1),
      .req_component_2   (req_component_2),
      .req_component_3   (req_component_3),
      .rsp_valid         (rsp_valid),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_is_new        (rsp_is_new),
      .rsp_table_full    (rsp_table_full),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   vtdi_index_checker index_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_of_mesh (req_start_of_mesh),
      .req_component_0   (req_component_0),
      .req_component_1   (req_component_1),
      .req_component_2   (req_component_2),
      .req_component_3   (req_component_3),
      .rsp_valid         (rsp_valid),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_is_new        (rsp_is_new),
      .rsp_table_full    (rsp_table_full),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .new_count         (new_count),
      .full_count        (full_count)
   );

   function automatic logic [INDEX_BITS-1:0] pick_component();
      case ($urandom_range(0, 4))
         0: return INDEX_BITS'($urandom_range(0, 15));
         1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         default: return INDEX_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_tuple();
      return {pick_component(), pick_component(), pick_component(), pick_component()};
   endfunction

   // Present one corner and hold it until the transaction is taken.
   task automatic send_corner(input logic som, input logic [KEY_BITS-1:0] tuple);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      req_start_of_mesh <= som;
      req_component_0 <= tuple[15:0];
      req_component_1 <= tuple[31:16];
      req_component_2 <= tuple[47:32];
      req_component_3 <= tuple[63:48];
      @(posedge clock);
      while (busy) @(posedge clock);
      corners_sent++;
   endtask

   // Hold the sender off until every outstanding result is back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_key_width(input logic [CCOUNT_BITS-1:0] value);
      drain();
      repeat (2) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_writes++;
   endtask

   // Corners drawn from a small pool so that repeats hit stored tuples.
   task automatic run_mesh(input int distinct, input int corners, input bit with_som);
      logic [KEY_BITS-1:0] pool [$];
      logic [KEY_BITS-1:0] tuple;
      int                  pick;
      logic                som;
      for (int i = 0; i < distinct; i++)
         pool.push_back(pick_tuple());
      for (int k = 0; k < corners; k++) begin
         pick = (k < distinct && $urandom_range(0, 1) != 0) ? k
                                                           : $urandom_range(0, distinct - 1);
         tuple = pool[pick];
         // vary the high components, which only count at larger widths
         if ($urandom_range(0, 5) == 0)
            tuple[63:32] = {pick_component(), pick_component()};
         if ($urandom_range(0, 39) == 0)
            tuple = pick_tuple();
         som = (with_som && k == 0) || ($urandom_range(0, 59) == 0);
         send_corner(som, tuple);
      end
      meshes++;
   endtask

   // Fill the whole table, then push stored and new tuples against it.
   task automatic run_fill_mesh();
      logic [INDEX_BITS-1:0] base;
      logic [KEY_BITS-1:0]   tuple;
      base = pick_component();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         fill_tuples[i] = {pick_component(), pick_component(), pick_component(),
                           INDEX_BITS'(base + i)};
         send_corner(i == 0, fill_tuples[i]);
      end
      send_corner(1'b0, fill_tuples[TABLE_DEPTH-1]);
      send_corner(1'b0, fill_tuples[0]);
      for (int j = 0; j < 3; j++) begin
         tuple = {pick_component(), pick_component(), pick_component(),
                  INDEX_BITS'(base + TABLE_DEPTH + j)};
         send_corner(1'b0, tuple);
      end
      send_corner(1'b0, fill_tuples[$urandom_range(0, TABLE_DEPTH - 1)]);
      meshes++;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, key width 3 out of reset
      send_corner(1'b1, 64'h0000_0000_0000_0000);
      send_corner(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_corner(1'b0, 64'h0000_0000_0000_0000);
      send_corner(1'b0, 64'hFFFF_0000_0000_0000);
      send_corner(1'b0, 64'h0000_FFFF_FFFF_FFFF);
      send_corner(1'b0, 64'h0004_0003_0002_0001);
      send_corner(1'b0, 64'h0009_0003_0002_0001);
      send_corner(1'b0, 64'h0004_0004_0002_0001);
      send_corner(1'b1, 64'h0004_0003_0002_0001);
      // widen mid-mesh: stored tuples compare with zero in the fourth slot
      write_key_width(3'd4);
      send_corner(1'b0, 64'h0004_0003_0002_0001);
      send_corner(1'b0, 64'h0000_0003_0002_0001);
      write_key_width(3'd0);
      send_corner(1'b0, 64'h0009_0009_0009_0001);
      send_corner(1'b0, 64'h0005_0005_0005_0001);
      write_key_width(3'd7);
      send_corner(1'b1, 64'h0008_0007_0006_0005);
      send_corner(1'b0, 64'h0008_0007_0006_0005);
      send_corner(1'b0, 64'h0009_0007_0006_0005);
      // tuples that would collide as joined decimal strings
      write_key_width(3'd2);
      send_corner(1'b1, 64'h0000_0000_0017_0001);
      send_corner(1'b0, 64'h0000_0000_0003_000C);
      send_corner(1'b0, 64'h0007_0007_0017_0001);
      write_key_width(3'd1);
      send_corner(1'b0, 64'h0004_0004_0004_000C);
      write_key_width(3'd5);
      send_corner(1'b1, 64'h5555_AAAA_5555_AAAA);
      send_corner(1'b0, 64'hAAAA_5555_AAAA_5555);
      send_corner(1'b0, 64'h5555_AAAA_5555_AAAA);
      meshes += 5;

      write_key_width(3'd3);
      while (corners_sent < 160) begin
         if ($urandom_range(0, 2) == 0)
            write_key_width(CCOUNT_BITS'($urandom_range(0, 7)));
         else if ($urandom_range(0, 3) == 0)
            drain();
         if ($urandom_range(0, 9) == 0)
            run_mesh($urandom_range(40, 120), $urandom_range(120, 200), 1'b1);
         else
            run_mesh($urandom_range(1, 24), $urandom_range(5, 50), $urandom_range(0, 9) != 0);
      end

      write_key_width(CCOUNT_BITS'($urandom_range(0, 7)));
      run_fill_mesh();

      while (corners_sent < 1300) begin
         if ($urandom_range(0, 2) == 0)
            write_key_width(CCOUNT_BITS'($urandom_range(0, 7)));
         run_mesh($urandom_range(1, 24), $urandom_range(5, 50), $urandom_range(0, 9) != 0);
      end

      drain();
      // catch any stray result, waiting long enough for a full scan of the table
      repeat (1100) @(posedge clock);

      if (outstanding != 0)
         $error("%0d results never arrived", outstanding);
      $display("Sent %0d corners in %0d meshes across %0d key-width writes",
               corners_sent, meshes, cfg_writes);
      $display("Saw %0d new tuples and %0d table-full results", new_count, full_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #64_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* vertex_tuple_dedup_indexer.f */
sv/vtdi_pkg.sv
sv/vtdi_ctrl.sv
sv/vtdi_datapath.sv
sv/vertex_tuple_dedup_indexer.sv
tb/sv/vtdi_index_checker.sv
tb/sv/tb_top.sv
